FILE: rtl/apt2d_pkg.sv
// Shared types, constants and fixed-point helpers of the 2D affine point transform.
// Used by every module of the block; depends on nothing else.
package apt2d_pkg;

  localparam int CW = 16;
  localparam int CF = 16;
  localparam int LW = CF + 8;
  localparam int CFG_IW = 3;

  localparam int ANGLE_FULL = 23040;
  localparam int ANGLE_QUARTER = 5760;
  localparam int ANGLE_EIGHTH = 2880;
  localparam logic [28:0] RAD_PER_UNIT = 29'd299845282;
  localparam logic [31:0] ONE_Q30 = 32'h4000_0000;

  localparam logic [CFG_IW-1:0] REG_SHIFT_X = 3'd0;
  localparam logic [CFG_IW-1:0] REG_SHIFT_Y = 3'd1;
  localparam logic [CFG_IW-1:0] REG_ANGLE = 3'd2;
  localparam logic [CFG_IW-1:0] REG_SCALE_X = 3'd3;
  localparam logic [CFG_IW-1:0] REG_SCALE_Y = 3'd4;
  localparam logic [CFG_IW-1:0] REG_SHEAR_X = 3'd5;
  localparam logic [CFG_IW-1:0] REG_SHEAR_Y = 3'd6;

  // Reciprocals of the Horner divisors: x / d is (x * MAG) >> SH for any x below 2**30.
  localparam logic [31:0] MAG_72 = 32'(((64'd1 << 37) + 64'd71) / 64'd72);
  localparam logic [31:0] MAG_42 = 32'(((64'd1 << 36) + 64'd41) / 64'd42);
  localparam logic [31:0] MAG_20 = 32'(((64'd1 << 35) + 64'd19) / 64'd20);
  localparam logic [31:0] MAG_6  = 32'(((64'd1 << 33) + 64'd5) / 64'd6);
  localparam logic [31:0] MAG_56 = 32'(((64'd1 << 36) + 64'd55) / 64'd56);
  localparam logic [31:0] MAG_30 = 32'(((64'd1 << 35) + 64'd29) / 64'd30);
  localparam logic [31:0] MAG_12 = 32'(((64'd1 << 34) + 64'd11) / 64'd12);
  localparam logic [31:0] MAG_2  = 32'(((64'd1 << 31) + 64'd1) / 64'd2);

  typedef logic signed [CW-1:0] coord_t;
  typedef logic signed [LW-1:0] coef_t;

  typedef struct packed {
    coef_t m00;
    coef_t m01;
    coef_t m10;
    coef_t m11;
  } lin_t;

  typedef struct packed {
    logic busy;
    coord_t shift_x;
    coord_t shift_y;
  } xlat_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    coord_t tx;
    coord_t ty;
  } work_t;

  typedef struct packed {
    coord_t x;
    coord_t y;
    logic ovf;
  } res_t;

  // Shift right with rounding half away from zero.
  function automatic logic signed [63:0] rnd_shift(input logic signed [63:0] v, input int sh);
    logic [63:0] mag;
    logic [63:0] half;
    half = (sh > 0) ? (64'd1 << (sh - 1)) : 64'd0;
    mag = v[63] ? 64'(-v) : 64'(v);
    mag = (mag + half) >> sh;
    return v[63] ? -$signed(mag) : $signed(mag);
  endfunction

  function automatic logic signed [63:0] to_frac(input logic signed [63:0] v, input int fb,
                                                 input int tb);
    if (tb >= fb) begin
      return v <<< (tb - fb);
    end
    return rnd_shift(v, fb - tb);
  endfunction

  function automatic coef_t sat_lin(input logic signed [63:0] v);
    logic signed [63:0] lim;
    lim = (64'sd1 <<< (LW - 1)) - 64'sd1;
    if (v > lim) begin
      return coef_t'(lim);
    end
    if (v < -lim) begin
      return coef_t'(-lim);
    end
    return coef_t'(v);
  endfunction

  // Reciprocal multipliers of the Horner steps: sine chain first, cosine chain second.
  function automatic logic [31:0] div_magic(input logic ph, input logic [1:0] it);
    case ({ph, it})
      3'd0: return MAG_72;
      3'd1: return MAG_42;
      3'd2: return MAG_20;
      3'd3: return MAG_6;
      3'd4: return MAG_56;
      3'd5: return MAG_30;
      3'd6: return MAG_12;
      default: return MAG_2;
    endcase
  endfunction

  function automatic logic [5:0] div_shift(input logic ph, input logic [1:0] it);
    case ({ph, it})
      3'd0: return 6'd37;
      3'd1: return 6'd36;
      3'd2: return 6'd35;
      3'd3: return 6'd33;
      3'd4: return 6'd36;
      3'd5: return 6'd35;
      3'd6: return 6'd34;
      default: return 6'd31;
    endcase
  endfunction

endpackage

FILE: rtl/apt2d_coeff.sv
// Configuration registers and the sequencer that derives the 2x2 linear matrix.
// Sine and cosine come from a Taylor series on a shared multiplier, dividing by reciprocals.
// Depends on apt2d_pkg.
module apt2d_coeff (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        cfg_we,
  input  logic [apt2d_pkg::CFG_IW-1:0] cfg_index,
  input  apt2d_pkg::coord_t           cfg_data,
  output apt2d_pkg::lin_t             lin,
  output apt2d_pkg::xlat_t            xlat
);
  import apt2d_pkg::*;

  localparam int TW = CF + 2;
  localparam int BW = CF + 11;
  localparam int RW = 2 * CF + 14;

  localparam logic [4:0] ST_IDLE  = 5'd0;
  localparam logic [4:0] ST_LOAD  = 5'd1;
  localparam logic [4:0] ST_WRAP  = 5'd2;
  localparam logic [4:0] ST_QUAD  = 5'd3;
  localparam logic [4:0] ST_FOLD  = 5'd4;
  localparam logic [4:0] ST_RAD   = 5'd5;
  localparam logic [4:0] ST_SQR   = 5'd6;
  localparam logic [4:0] ST_TMUL  = 5'd7;
  localparam logic [4:0] ST_DIV   = 5'd8;
  localparam logic [4:0] ST_CHEND = 5'd9;
  localparam logic [4:0] ST_ROUND = 5'd10;
  localparam logic [4:0] ST_B1    = 5'd11;
  localparam logic [4:0] ST_B2    = 5'd12;
  localparam logic [4:0] ST_B3    = 5'd13;
  localparam logic [4:0] ST_L1    = 5'd14;
  localparam logic [4:0] ST_L2    = 5'd15;
  localparam logic [4:0] ST_L3    = 5'd16;

  coord_t sx_r, sy_r, ang_cfg_r, scx_r, scy_r, kx_r, ky_r;
  lin_t lin_r;
  logic [4:0] st_r;
  logic start;

  logic signed [16:0] ang_r;
  logic [1:0] quad_r;
  logic [11:0] a_r;
  logic swap_r;
  logic [31:0] r_r, r2_r, t_r, dvd_r, sin_raw_r, cos_raw_r;
  logic [1:0] iter_r;
  logic phase_r;
  logic signed [TW-1:0] sn_r, cs_r;
  logic signed [31:0] pkx_r, pky_r, pkk_r;
  logic signed [49:0] pb11_r;
  logic signed [BW-1:0] b00_r, b01_r, b10_r, b11_r;
  logic signed [RW-1:0] raw0_r, raw1_r, raw2_r, raw3_r;

  logic [40:0] rad_prod;
  logic [31:0] mul_a, mul_b;
  logic [63:0] umul;
  logic [31:0] dmag;
  logic [5:0] dsh;
  logic [31:0] quot;
  logic [31:0] us, uc;
  logic signed [TW-1:0] s0, c0, sn_q, cs_q;

  always_comb begin
    start = 1'b0;
    case (cfg_index)
      REG_SHIFT_X, REG_SHIFT_Y, REG_ANGLE, REG_SCALE_X,
      REG_SCALE_Y, REG_SHEAR_X, REG_SHEAR_Y: start = cfg_we;
      default: start = 1'b0;
    endcase
  end

  always_comb begin
    case (st_r)
      ST_SQR: begin
        mul_a = r_r;
        mul_b = r_r;
      end
      ST_TMUL: begin
        mul_a = r2_r;
        mul_b = t_r;
      end
      ST_DIV: begin
        mul_a = dvd_r;
        mul_b = dmag;
      end
      default: begin
        mul_a = r_r;
        mul_b = t_r;
      end
    endcase
  end

  assign umul = mul_a * mul_b;
  assign rad_prod = a_r * RAD_PER_UNIT;

  assign dmag = div_magic(phase_r, iter_r);
  assign dsh = div_shift(phase_r, iter_r);
  assign quot = 32'(umul >> dsh);

  always_comb begin
    us = swap_r ? cos_raw_r : sin_raw_r;
    uc = swap_r ? sin_raw_r : cos_raw_r;
    s0 = TW'(rnd_shift(64'(us), 30 - CF));
    c0 = TW'(rnd_shift(64'(uc), 30 - CF));
    case (quad_r)
      2'd0: begin
        sn_q = s0;
        cs_q = c0;
      end
      2'd1: begin
        sn_q = c0;
        cs_q = -s0;
      end
      2'd2: begin
        sn_q = -s0;
        cs_q = -c0;
      end
      default: begin
        sn_q = -c0;
        cs_q = s0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sx_r <= '0;
      sy_r <= '0;
      ang_cfg_r <= '0;
      scx_r <= coord_t'(4096);
      scy_r <= coord_t'(4096);
      kx_r <= '0;
      ky_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SHIFT_X: sx_r <= cfg_data;
        REG_SHIFT_Y: sy_r <= cfg_data;
        REG_ANGLE:   ang_cfg_r <= cfg_data;
        REG_SCALE_X: scx_r <= cfg_data;
        REG_SCALE_Y: scy_r <= cfg_data;
        REG_SHEAR_X: kx_r <= cfg_data;
        REG_SHEAR_Y: ky_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      lin_r.m00 <= coef_t'(64'sd1 <<< CF);
      lin_r.m01 <= '0;
      lin_r.m10 <= '0;
      lin_r.m11 <= coef_t'(64'sd1 <<< CF);
    end else if (start) begin
      st_r <= ST_LOAD;
    end else begin
      case (st_r)
        ST_IDLE: st_r <= ST_IDLE;
        ST_LOAD: begin
          ang_r <= 17'(ang_cfg_r);
          quad_r <= 2'd0;
          st_r <= ST_WRAP;
        end
        ST_WRAP: begin
          if (ang_r < 0) begin
            ang_r <= 17'(ang_r + ANGLE_FULL);
          end else if (ang_r >= ANGLE_FULL) begin
            ang_r <= 17'(ang_r - ANGLE_FULL);
          end else begin
            st_r <= ST_QUAD;
          end
        end
        ST_QUAD: begin
          if (ang_r >= ANGLE_QUARTER) begin
            ang_r <= 17'(ang_r - ANGLE_QUARTER);
            quad_r <= quad_r + 2'd1;
          end else begin
            st_r <= ST_FOLD;
          end
        end
        ST_FOLD: begin
          if (ang_r > ANGLE_EIGHTH) begin
            a_r <= 12'(ANGLE_QUARTER - ang_r);
            swap_r <= 1'b1;
          end else begin
            a_r <= 12'(ang_r);
            swap_r <= 1'b0;
          end
          st_r <= ST_RAD;
        end
        ST_RAD: begin
          r_r <= 32'(rad_prod >> 10);
          st_r <= ST_SQR;
        end
        ST_SQR: begin
          r2_r <= umul[61:30];
          t_r <= ONE_Q30;
          iter_r <= 2'd0;
          phase_r <= 1'b0;
          st_r <= ST_TMUL;
        end
        ST_TMUL: begin
          dvd_r <= umul[61:30];
          st_r <= ST_DIV;
        end
        ST_DIV: begin
          t_r <= ONE_Q30 - quot;
          iter_r <= iter_r + 2'd1;
          st_r <= (iter_r == 2'd3) ? ST_CHEND : ST_TMUL;
        end
        ST_CHEND: begin
          if (!phase_r) begin
            sin_raw_r <= umul[61:30];
            t_r <= ONE_Q30;
            iter_r <= 2'd0;
            phase_r <= 1'b1;
            st_r <= ST_TMUL;
          end else begin
            cos_raw_r <= t_r;
            st_r <= ST_ROUND;
          end
        end
        ST_ROUND: begin
          sn_r <= sn_q;
          cs_r <= cs_q;
          st_r <= ST_B1;
        end
        ST_B1: begin
          pkx_r <= kx_r * scy_r;
          pky_r <= ky_r * scx_r;
          pkk_r <= ky_r * kx_r;
          b00_r <= BW'(to_frac(64'(scx_r), 12, CF));
          st_r <= ST_B2;
        end
        ST_B2: begin
          b01_r <= BW'(to_frac(64'(pkx_r), 24, CF));
          b10_r <= BW'(to_frac(64'(pky_r), 24, CF));
          pb11_r <= pkk_r * scy_r + (50'(scy_r) <<< 24);
          st_r <= ST_B3;
        end
        ST_B3: begin
          b11_r <= BW'(to_frac(64'(pb11_r), 36, CF));
          st_r <= ST_L1;
        end
        ST_L1: begin
          raw0_r <= cs_r * b00_r - sn_r * b10_r;
          raw1_r <= cs_r * b01_r - sn_r * b11_r;
          st_r <= ST_L2;
        end
        ST_L2: begin
          raw2_r <= sn_r * b00_r + cs_r * b10_r;
          raw3_r <= sn_r * b01_r + cs_r * b11_r;
          st_r <= ST_L3;
        end
        ST_L3: begin
          lin_r.m00 <= sat_lin(rnd_shift(64'(raw0_r), CF));
          lin_r.m01 <= sat_lin(rnd_shift(64'(raw1_r), CF));
          lin_r.m10 <= sat_lin(rnd_shift(64'(raw2_r), CF));
          lin_r.m11 <= sat_lin(rnd_shift(64'(raw3_r), CF));
          st_r <= ST_IDLE;
        end
        default: st_r <= ST_IDLE;
      endcase
    end
  end

  assign lin = lin_r;
  assign xlat.busy = (st_r != ST_IDLE);
  assign xlat.shift_x = sx_r;
  assign xlat.shift_y = sy_r;

endmodule

FILE: rtl/apt2d_front.sv
// Input side: takes coordinate items, picks their translation by the point flag,
// and holds them in a four-entry queue for the arithmetic side. Depends on apt2d_pkg.
module apt2d_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  output logic              full,
  input  apt2d_pkg::coord_t x_in,
  input  apt2d_pkg::coord_t y_in,
  input  logic              is_point,
  input  apt2d_pkg::xlat_t  xlat,
  output logic              q_valid,
  input  logic              q_pop,
  output apt2d_pkg::work_t  q_head
);
  import apt2d_pkg::*;

  localparam int QD = 4;

  work_t mem_r [QD];
  logic [1:0] wr_ptr_r, rd_ptr_r;
  logic [2:0] cnt_r, cnt_nxt;
  logic wr, rd;
  work_t entry;

  assign full = xlat.busy || (cnt_r == 3'(QD));
  assign wr = push && !full;
  assign rd = q_pop && q_valid;
  assign q_valid = (cnt_r != 3'd0);
  assign q_head = mem_r[rd_ptr_r];

  always_comb begin
    entry.x = x_in;
    entry.y = y_in;
    entry.tx = is_point ? xlat.shift_x : '0;
    entry.ty = is_point ? xlat.shift_y : '0;
    cnt_nxt = cnt_r + 3'(wr) - 3'(rd);
  end

  always_ff @(posedge clk) begin
    if (wr) begin
      mem_r[wr_ptr_r] <= entry;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r <= '0;
    end else begin
      if (wr) begin
        wr_ptr_r <= wr_ptr_r + 2'd1;
      end
      if (rd) begin
        rd_ptr_r <= rd_ptr_r + 2'd1;
      end
      cnt_r <= cnt_nxt;
    end
  end

endmodule

FILE: rtl/apt2d_back.sv
// Arithmetic side: two-stage multiply and round, then translation and saturation
// into a four-entry result queue. Depends on apt2d_pkg.
module apt2d_back (
  input  logic              clk,
  input  logic              rst_n,
  input  apt2d_pkg::lin_t   lin,
  input  logic              q_valid,
  output logic              q_pop,
  input  apt2d_pkg::work_t  q_head,
  output logic              empty,
  input  logic              pop,
  output apt2d_pkg::res_t   res
);
  import apt2d_pkg::*;

  localparam int PW = LW + CW;
  localparam int SW = PW + 1;
  localparam int XW = SW + 1;
  localparam int OD = 4;
  localparam logic signed [XW-1:0] CMAX = XW'((64'sd1 <<< (CW - 1)) - 64'sd1);
  localparam logic signed [XW-1:0] CMIN = XW'(-(64'sd1 <<< (CW - 1)));

  logic signed [PW-1:0] p00_r, p01_r, p10_r, p11_r;
  coord_t tx_a_r, ty_a_r, tx_b_r, ty_b_r;
  logic signed [SW-1:0] xr_b_r, yr_b_r;
  logic va_r, vb_r;

  logic signed [SW-1:0] sum_x, sum_y;
  logic signed [XW-1:0] xt, yt;
  res_t wres;

  res_t omem_r [OD];
  logic [1:0] owr_r, ord_r;
  logic [2:0] ocnt_r;
  logic ord;

  assign q_pop = q_valid && (({1'b0, ocnt_r} + 4'(va_r) + 4'(vb_r)) < 4'(OD));

  assign sum_x = SW'(p00_r) + SW'(p01_r);
  assign sum_y = SW'(p10_r) + SW'(p11_r);

  always_ff @(posedge clk) begin
    if (q_pop) begin
      p00_r <= lin.m00 * q_head.x;
      p01_r <= lin.m01 * q_head.y;
      p10_r <= lin.m10 * q_head.x;
      p11_r <= lin.m11 * q_head.y;
      tx_a_r <= q_head.tx;
      ty_a_r <= q_head.ty;
    end
    if (va_r) begin
      xr_b_r <= SW'(rnd_shift(64'(sum_x), CF));
      yr_b_r <= SW'(rnd_shift(64'(sum_y), CF));
      tx_b_r <= tx_a_r;
      ty_b_r <= ty_a_r;
    end
  end

  always_comb begin
    xt = XW'(xr_b_r) + XW'(tx_b_r);
    yt = XW'(yr_b_r) + XW'(ty_b_r);
    wres.ovf = 1'b0;
    if (xt > CMAX) begin
      wres.x = coord_t'(CMAX);
      wres.ovf = 1'b1;
    end else if (xt < CMIN) begin
      wres.x = coord_t'(CMIN);
      wres.ovf = 1'b1;
    end else begin
      wres.x = coord_t'(xt);
    end
    if (yt > CMAX) begin
      wres.y = coord_t'(CMAX);
      wres.ovf = 1'b1;
    end else if (yt < CMIN) begin
      wres.y = coord_t'(CMIN);
      wres.ovf = 1'b1;
    end else begin
      wres.y = coord_t'(yt);
    end
  end

  assign empty = (ocnt_r == 3'd0);
  assign ord = pop && !empty;
  assign res = omem_r[ord_r];

  always_ff @(posedge clk) begin
    if (vb_r) begin
      omem_r[owr_r] <= wres;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      va_r <= 1'b0;
      vb_r <= 1'b0;
      owr_r <= '0;
      ord_r <= '0;
      ocnt_r <= '0;
    end else begin
      va_r <= q_pop;
      vb_r <= va_r;
      if (vb_r) begin
        owr_r <= owr_r + 2'd1;
      end
      if (ord) begin
        ord_r <= ord_r + 2'd1;
      end
      ocnt_r <= ocnt_r + 3'(vb_r) - 3'(ord);
    end
  end

endmodule

FILE: rtl/affine_point_transform_2d_top.sv
// Top level of the 2D affine point transform: config port, input queue, arithmetic side.
// Depends on apt2d_pkg, apt2d_coeff, apt2d_front and apt2d_back.
//
// Usage: the input side is a queue. An item (in_x_in, in_y_in, in_is_point) transfers
// at a clock edge with push high and full low. Results are read like a queue too: while
// empty is low the oldest result sits on out_x_out, out_y_out and out_overflow, and it
// transfers at an edge with pop high. Points get the translation, directions do not.
// Throughput is one item per cycle while full is low and the reader keeps popping. A
// result passes the input queue, a registered multiply stage and a registered rounding
// stage, then the translated and saturated value lands in a four-entry result queue.
// A write on cfg_we/cfg_index/cfg_data to a mapped index takes effect at once in the
// register and starts the matrix derivation sequencer (angle reduction, two Horner
// chains of four multiply steps each, then the matrix products). full stays high while
// it runs.
// When the reader stalls, the result queue fills, the arithmetic side stops issuing,
// the input queue fills and full rises; nothing is dropped.
// Reset (rst_n low, synchronous) empties both queues and restores identity matrix,
// zero translation, zero angle, unit scales and zero shears.
module affine_point_transform_2d_top (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push,
  output logic                         full,
  input  apt2d_pkg::coord_t            in_x_in,
  input  apt2d_pkg::coord_t            in_y_in,
  input  logic                         in_is_point,
  output logic                         empty,
  input  logic                         pop,
  output apt2d_pkg::coord_t            out_x_out,
  output apt2d_pkg::coord_t            out_y_out,
  output logic                         out_overflow,
  input  logic                         cfg_we,
  input  logic [apt2d_pkg::CFG_IW-1:0] cfg_index,
  input  apt2d_pkg::coord_t            cfg_data
);
  import apt2d_pkg::*;

  lin_t lin;
  xlat_t xlat;
  logic q_valid, q_pop;
  work_t q_head;
  res_t res;

  apt2d_coeff u_coeff (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .lin       (lin),
    .xlat      (xlat)
  );

  apt2d_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .full     (full),
    .x_in     (in_x_in),
    .y_in     (in_y_in),
    .is_point (in_is_point),
    .xlat     (xlat),
    .q_valid  (q_valid),
    .q_pop    (q_pop),
    .q_head   (q_head)
  );

  apt2d_back u_back (
    .clk     (clk),
    .rst_n   (rst_n),
    .lin     (lin),
    .q_valid (q_valid),
    .q_pop   (q_pop),
    .q_head  (q_head),
    .empty   (empty),
    .pop     (pop),
    .res     (res)
  );

  assign out_x_out = res.x;
  assign out_y_out = res.y;
  assign out_overflow = res.ovf;

endmodule

FILE: verif/tb_top.sv
// Self-checking testbench for affine_point_transform_2d_top: transfers coordinate pairs,
// predicts each transformed pair in fixed point and compares every result transfer.
// Depends on apt2d_pkg and the RTL of the block.
`timescale 1ns / 1ps

module tb_top;
  import apt2d_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam logic [CFG_IW-1:0] REG_UNMAPPED = 3'd7;

  typedef struct {
    coord_t x;
    coord_t y;
    logic   ovf;
  } xform_t;

  logic clk;
  logic rst_n;
  logic push;
  logic full;
  coord_t in_x_in;
  coord_t in_y_in;
  logic in_is_point;
  logic empty;
  logic pop;
  coord_t out_x_out;
  coord_t out_y_out;
  logic out_overflow;
  logic cfg_we;
  logic [CFG_IW-1:0] cfg_index;
  coord_t cfg_data;

  xform_t pending_q[$];
  int errors = 0;
  int idle_cycles = 0;
  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  int rx_hold_req = 0;
  int rx_hold = 0;

  longint shift_x_m, shift_y_m, angle_m, scale_x_m, scale_y_m, shear_x_m, shear_y_m;
  longint lin_m[4];

  affine_point_transform_2d_top DUT (
    .clk(clk), .rst_n(rst_n), .push(push), .full(full), .in_x_in(in_x_in),
    .in_y_in(in_y_in), .in_is_point(in_is_point), .empty(empty), .pop(pop),
    .out_x_out(out_x_out), .out_y_out(out_y_out), .out_overflow(out_overflow),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic longint round_away(longint v, int sh);
    longint half;
    half = (sh > 0) ? (64'sd1 <<< (sh - 1)) : 0;
    if (v >= 0) begin
      return (v + half) >>> sh;
    end
    return -((-v + half) >>> sh);
  endfunction

  function automatic longint clamp_val(longint v, longint lo, longint hi, ref bit hit);
    if (v > hi) begin
      hit = 1'b1;
      return hi;
    end
    if (v < lo) begin
      hit = 1'b1;
      return lo;
    end
    return v;
  endfunction

  task automatic octant_sin_cos(input longint unsigned a, output longint unsigned sn,
                                output longint unsigned cs);
    longint unsigned r, r2, t, one;
    one = 64'd1 << 30;
    r = (a * 64'd299845282) >> 10;
    r2 = (r * r) >> 30;
    t = one - r2 / 72;
    t = one - ((r2 * t) >> 30) / 42;
    t = one - ((r2 * t) >> 30) / 20;
    t = one - ((r2 * t) >> 30) / 6;
    sn = (r * t) >> 30;
    t = one - r2 / 56;
    t = one - ((r2 * t) >> 30) / 30;
    t = one - ((r2 * t) >> 30) / 12;
    t = one - ((r2 * t) >> 30) / 2;
    cs = t;
  endtask

  task automatic rotation_sin_cos(input longint ang, output longint sn, output longint cs);
    longint m, q, rem, s0, c0;
    longint unsigned us, uc;
    m = ang % ANGLE_FULL;
    if (m < 0) m += ANGLE_FULL;
    q = m / ANGLE_QUARTER;
    rem = m % ANGLE_QUARTER;
    if (rem <= ANGLE_EIGHTH) octant_sin_cos(rem, us, uc);
    else octant_sin_cos(ANGLE_QUARTER - rem, uc, us);
    s0 = round_away(longint'(us), 30 - CF);
    c0 = round_away(longint'(uc), 30 - CF);
    case (q)
      0: begin sn = s0; cs = c0; end
      1: begin sn = c0; cs = -s0; end
      2: begin sn = -s0; cs = -c0; end
      default: begin sn = -c0; cs = s0; end
    endcase
  endtask

  task automatic derive_linear_part();
    longint lim, sn, cs, b00, b01, b10, b11;
    longint raw[4];
    bit dummy;
    lim = (64'sd1 <<< (LW - 1)) - 1;
    rotation_sin_cos(angle_m, sn, cs);
    b00 = scale_x_m <<< (CF - 12);
    b01 = round_away(shear_x_m * scale_y_m, 24 - CF);
    b10 = round_away(shear_y_m * scale_x_m, 24 - CF);
    b11 = round_away(shear_y_m * shear_x_m * scale_y_m + (scale_y_m <<< 24), 36 - CF);
    raw[0] = cs * b00 - sn * b10;
    raw[1] = cs * b01 - sn * b11;
    raw[2] = sn * b00 + cs * b10;
    raw[3] = sn * b01 + cs * b11;
    for (int i = 0; i < 4; i++) lin_m[i] = clamp_val(round_away(raw[i], CF), -lim, lim, dummy);
  endtask

  function automatic xform_t transform_pair(coord_t x, coord_t y, logic is_point);
    xform_t r;
    longint xo, yo;
    bit hit;
    hit = 1'b0;
    xo = round_away(lin_m[0] * longint'(x) + lin_m[1] * longint'(y), CF);
    yo = round_away(lin_m[2] * longint'(x) + lin_m[3] * longint'(y), CF);
    if (is_point) begin
      xo += shift_x_m;
      yo += shift_y_m;
    end
    r.x = coord_t'(clamp_val(xo, -32768, 32767, hit));
    r.y = coord_t'(clamp_val(yo, -32768, 32767, hit));
    r.ovf = hit;
    return r;
  endfunction

  // Result side: checks each transfer, drives pop and runs the watchdog.
  always @(posedge clk) begin
    xform_t e;
    if (rst_n) begin
      if ((push && !full) || (pop && !empty)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (pop && !empty) begin
        if (pending_q.size() == 0) begin
          $display("%0t: unexpected result x=%0d y=%0d ovf=%0b", $time, out_x_out,
                   out_y_out, out_overflow);
          errors++;
        end else begin
          e = pending_q.pop_front();
          if (out_x_out !== e.x) begin
            $display("%0t: x_out expected %0d actual %0d", $time, e.x, out_x_out);
            errors++;
          end
          if (out_y_out !== e.y) begin
            $display("%0t: y_out expected %0d actual %0d", $time, e.y, out_y_out);
            errors++;
          end
          if (out_overflow !== e.ovf) begin
            $display("%0t: overflow expected %0b actual %0b", $time, e.ovf, out_overflow);
            errors++;
          end
        end
      end
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("TB_ERROR");
        $finish;
      end
    end
    if (rx_hold_req > 0) begin
      rx_hold = rx_hold_req;
      rx_hold_req = 0;
    end
    if (rx_hold > 0) begin
      rx_hold--;
      pop <= 1'b0;
    end else begin
      pop <= ($urandom_range(0, 99) >= rx_stall_pct);
    end
  end

  task automatic send_pair(coord_t x, coord_t y, logic is_point);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    push <= 1'b1;
    in_x_in <= x;
    in_y_in <= y;
    in_is_point <= is_point;
    do @(posedge clk); while (full);
    pending_q.insert(pending_q.size(), transform_pair(x, y, is_point));
  endtask

  task automatic wait_drained();
    push <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_reg(logic [CFG_IW-1:0] idx, coord_t val);
    wait_drained();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_SHIFT_X: shift_x_m = val;
      REG_SHIFT_Y: shift_y_m = val;
      REG_ANGLE:   angle_m = val;
      REG_SCALE_X: scale_x_m = val;
      REG_SCALE_Y: scale_y_m = val;
      REG_SHEAR_X: shear_x_m = val;
      REG_SHEAR_Y: shear_y_m = val;
      default: ;
    endcase
    if (idx <= REG_SHEAR_Y) derive_linear_part();
    else repeat (300) @(posedge clk);
    repeat (2) @(posedge clk);
    while (full) @(posedge clk);
  endtask

  function automatic coord_t rand_coord();
    case ($urandom_range(0, 3))
      0: return coord_t'($urandom_range(0, 511) - 256);
      1: return $urandom_range(0, 1) ? 16'sh7fff : 16'sh8000;
      default: return coord_t'($urandom_range(0, 65535));
    endcase
  endfunction

  task automatic send_random(int n);
    for (int i = 0; i < n; i++) send_pair(rand_coord(), rand_coord(), 1'($urandom_range(0, 1)));
  endtask

  task automatic randomize_config();
    write_reg(REG_SHIFT_X, rand_coord());
    write_reg(REG_SHIFT_Y, rand_coord());
    write_reg(REG_ANGLE, $urandom_range(0, 3) == 0 ? coord_t'($urandom_range(0, 65535))
                                                    : coord_t'($urandom_range(0, 46080) - 23040));
    write_reg(REG_SCALE_X, $urandom_range(0, 2) == 0 ? rand_coord()
                                                      : coord_t'($urandom_range(0, 16384) - 8192));
    write_reg(REG_SCALE_Y, $urandom_range(0, 2) == 0 ? rand_coord()
                                                      : coord_t'($urandom_range(0, 16384) - 8192));
    write_reg(REG_SHEAR_X, $urandom_range(0, 2) == 0 ? rand_coord()
                                                      : coord_t'($urandom_range(0, 8192) - 4096));
    write_reg(REG_SHEAR_Y, $urandom_range(0, 2) == 0 ? rand_coord()
                                                      : coord_t'($urandom_range(0, 8192) - 4096));
  endtask

  task automatic test_reset_identity();
    send_pair(16'sh7fff, 16'sh8000, 1'b1);
    send_pair(16'sh8000, 16'sh7fff, 1'b0);
    send_pair(16'sh0000, 16'shffff, 1'b1);
    send_pair(16'sh5555, 16'shaaaa, 1'b0);
  endtask

  task automatic test_directed_corners();
    write_reg(REG_SHIFT_X, 16'sh7fff);
    write_reg(REG_SHIFT_Y, 16'sh8000);
    send_pair(16'sh0100, 16'shff00, 1'b1);
    send_pair(16'sh0100, 16'shff00, 1'b0);
    write_reg(REG_ANGLE, 16'sd5760);
    send_pair(16'sh0100, 16'sh0200, 1'b0);
    write_reg(REG_ANGLE, 16'sd2880);
    send_pair(16'sh7fff, 16'sh7fff, 1'b0);
    write_reg(REG_ANGLE, -16'sd23040);
    send_pair(16'sh1234, 16'sh8000, 1'b1);
    write_reg(REG_ANGLE, 16'sd23040);
    write_reg(REG_SCALE_X, 16'sh7fff);
    write_reg(REG_SCALE_Y, 16'sh8000);
    write_reg(REG_SHEAR_X, 16'sh7fff);
    write_reg(REG_SHEAR_Y, 16'sh8000);
    send_pair(16'sh7fff, 16'sh8000, 1'b1);
    send_pair(16'sh0001, 16'shffff, 1'b0);
    write_reg(REG_ANGLE, 16'sh7fff);
    send_pair(16'sh0100, 16'sh0100, 1'b0);
    write_reg(REG_ANGLE, 16'sh8000);
    send_pair(16'sh0100, 16'sh0100, 1'b1);
  endtask

  task automatic test_unknown_index();
    write_reg(REG_UNMAPPED, 16'sh1234);
    send_pair(16'sh0321, 16'shfedc, 1'b1);
  endtask

  task automatic test_idle_phases();
    int pcts[4][2] = '{'{0, 0}, '{74, 0}, '{0, 74}, '{21, 21}};
    for (int s = 0; s < 12; s++) begin
      tx_idle_pct = pcts[s % 4][0];
      rx_stall_pct = pcts[s % 4][1];
      randomize_config();
      send_random(150);
    end
    tx_idle_pct = 0;
    rx_stall_pct = 0;
  endtask

  task automatic test_backpressure();
    rx_hold_req = 400;
    send_random(60);
    wait_drained();
    send_random(40);
  endtask

  initial begin
    rst_n = 1'b0;
    push = 1'b0;
    pop = 1'b0;
    in_x_in = '0;
    in_y_in = '0;
    in_is_point = 1'b0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    shift_x_m = 0; shift_y_m = 0; angle_m = 0;
    scale_x_m = 4096; scale_y_m = 4096; shear_x_m = 0; shear_y_m = 0;
    lin_m = '{65536, 0, 0, 65536};
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_reset_identity();
    test_directed_corners();
    test_unknown_index();
    test_idle_phases();
    test_backpressure();
    wait_drained();
    repeat (20) @(posedge clk);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
